// File: sv/encoder_odometry_tracker_unit_defines.svh
// Assertion macros shared by the odometry tracker RTL.
// Depends on nothing; the modules that assert take it by include and provide clk and rst_n.
`ifndef ENCODER_ODOMETRY_TRACKER_UNIT_DEFINES_SVH
`define ENCODER_ODOMETRY_TRACKER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// The condition must never be seen at a clock edge outside reset.
`define EOT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
// The antecedent at a clock edge implies the consequent at the same edge.
`define EOT_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define EOT_ASSERT_NEVER(lbl, cond, msg)
`define EOT_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

// File: sv/eot_pkg.sv
// Types, constants and trig helpers for the encoder odometry tracker.
// Depends on nothing; the front end, back end, top level and testbench use it by scoped names.
package eot_pkg;

  localparam int ANGLE_BITS_DEF  = 16;
  localparam int POS_BITS_DEF    = 32;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int PHASE_BITS = 20;
  localparam int STEP_BITS  = 24;
  localparam int TMAG_BITS  = 15;
  localparam int PROD_BITS  = STEP_BITS + TMAG_BITS;
  localparam int DELTA_BITS = 25;

  localparam logic [PHASE_BITS-1:0] QUARTER_PH = PHASE_BITS'(1) << (PHASE_BITS - 2);
  localparam logic [PHASE_BITS-1:0] HALF_PH    = PHASE_BITS'(1) << (PHASE_BITS - 1);

  // Input modes.
  localparam logic [1:0] MODE_X_TICK = 2'd0;
  localparam logic [1:0] MODE_Y_TICK = 2'd1;
  localparam logic [1:0] MODE_LOAD   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_STEP_X      = 2'd0;
  localparam logic [1:0] REG_STEP_Y      = 2'd1;
  localparam logic [1:0] REG_CENTER_DIST = 2'd2;
  localparam logic [1:0] REG_OFFSET_ANG  = 2'd3;

  typedef enum logic [1:0] {
    OP_MOVE,
    OP_LOAD,
    OP_HOLD
  } eot_op_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic               forward;
    logic [15:0]        heading;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
  } eot_in_word_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
  } eot_out_word_t;

  typedef struct packed {
    logic [STEP_BITS-1:0] step_x;
    logic [STEP_BITS-1:0] step_y;
    logic [STEP_BITS-1:0] center_distance;
    logic [15:0]          offset_angle;
  } eot_cfg_t;

  // Sine or cosine as sign and magnitude, magnitude up to 32767.
  typedef struct packed {
    logic                 neg;
    logic [TMAG_BITS-1:0] mag;
  } eot_trig_t;

  // Work handed from the front end to the accumulator.
  typedef struct packed {
    eot_op_t                 op;
    logic signed [31:0]      load_x;
    logic signed [31:0]      load_y;
    logic signed [DELTA_BITS-1:0] dx;
    logic signed [DELTA_BITS-1:0] dy;
    logic signed [DELTA_BITS-1:0] ox;
    logic signed [DELTA_BITS-1:0] oy;
  } eot_mid_word_t;

  // Quarter-wave sine, round(32767*sin(k*pi/64)) for k = 0..32.
  function automatic logic [TMAG_BITS-1:0] quarter_sine(input logic [5:0] idx);
    logic [TMAG_BITS-1:0] v;
    case (idx)
      6'd0:  v = 15'd0;     6'd1:  v = 15'd1608;  6'd2:  v = 15'd3212;
      6'd3:  v = 15'd4808;  6'd4:  v = 15'd6393;  6'd5:  v = 15'd7962;
      6'd6:  v = 15'd9512;  6'd7:  v = 15'd11039; 6'd8:  v = 15'd12539;
      6'd9:  v = 15'd14010; 6'd10: v = 15'd15446; 6'd11: v = 15'd16846;
      6'd12: v = 15'd18204; 6'd13: v = 15'd19519; 6'd14: v = 15'd20787;
      6'd15: v = 15'd22005; 6'd16: v = 15'd23170; 6'd17: v = 15'd24279;
      6'd18: v = 15'd25329; 6'd19: v = 15'd26319; 6'd20: v = 15'd27245;
      6'd21: v = 15'd28105; 6'd22: v = 15'd28898; 6'd23: v = 15'd29621;
      6'd24: v = 15'd30273; 6'd25: v = 15'd30852; 6'd26: v = 15'd31356;
      6'd27: v = 15'd31785; 6'd28: v = 15'd32137; 6'd29: v = 15'd32412;
      6'd30: v = 15'd32609; 6'd31: v = 15'd32728; 6'd32: v = 15'd32767;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Interpolated sine of a 20-bit phase, rounding the interpolation half up.
  function automatic eot_trig_t sine_q15(input logic [PHASE_BITS-1:0] ph);
    logic [1:0]           q;
    logic [18:0]          r;
    logic [5:0]           idx;
    logic [12:0]          frac;
    logic [TMAG_BITS-1:0] lo;
    logic [TMAG_BITS-1:0] hi;
    logic [10:0]          d;
    logic [24:0]          interp;
    eot_trig_t            t;
    q      = ph[PHASE_BITS-1:PHASE_BITS-2];
    r      = q[0] ? (19'h40000 - {1'b0, ph[17:0]}) : {1'b0, ph[17:0]};
    idx    = r[18:13];
    frac   = r[12:0];
    lo     = quarter_sine(idx);
    hi     = quarter_sine(idx + 6'd1);
    d      = 11'(hi - lo);
    interp = {14'd0, d} * {12'd0, frac} + 25'd4096;
    t.neg  = q[1];
    t.mag  = idx[5] ? 15'd32767 : (lo + 15'(interp[24:13]));
    return t;
  endfunction

  // round(product / 32768) with halves away from zero, sign applied last.
  function automatic logic signed [DELTA_BITS-1:0] scale_round(
    input logic [PROD_BITS-1:0] prod,
    input logic                 neg
  );
    logic [PROD_BITS:0]    s;
    logic [DELTA_BITS-1:0] m;
    s = {1'b0, prod} + (PROD_BITS+1)'(16384);
    m = s[PROD_BITS:15];
    return neg ? -signed'(m) : signed'(m);
  endfunction

endpackage

// File: sv/eot_fifo.sv
// Small register queue used between the front end and the accumulator and at the output.
// Depends on encoder_odometry_tracker_unit_defines.svh for its assertions.
`include "encoder_odometry_tracker_unit_defines.svh"

module eot_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem[rd_ptr_r];
  assign empty    = (count_r == '0);

  `EOT_ASSERT_NEVER(a_fifo_no_overflow, push && !pop && (count_r == CW'(DEPTH)), "queue overflow")
  `EOT_ASSERT_NEVER(a_fifo_no_underflow, pop && (count_r == '0), "queue underflow")

endmodule

// File: sv/eot_front.sv
// Front end: accepts input words, classifies them and forms the scaled step and offset vectors.
// Depends on eot_pkg and encoder_odometry_tracker_unit_defines.svh.
`include "encoder_odometry_tracker_unit_defines.svh"

module eot_front #(
  parameter int ANGLE_BITS  = eot_pkg::ANGLE_BITS_DEF,
  parameter int QUEUE_DEPTH = eot_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  eot_pkg::eot_in_word_t in_word,
  output logic                  in_full,
  input  eot_pkg::eot_cfg_t     cfg,
  input  logic                  mid_pop,
  output logic                  mid_push,
  output eot_pkg::eot_mid_word_t mid_word
);

  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SHIFT = eot_pkg::PHASE_BITS - ANGLE_BITS;

  logic                              accept;
  logic [ANGLE_BITS-1:0]             head_a;
  logic [ANGLE_BITS-1:0]             off_a;
  logic [eot_pkg::PHASE_BITS-1:0]    head_ph, off_ph, tick_ph, cen_ph;
  eot_pkg::eot_op_t                  op;
  logic [CW-1:0]                     cnt_r, cnt_nxt;

  // Stage 1: trig values.
  logic                              f1_v_r;
  eot_pkg::eot_op_t                  f1_op_r;
  logic signed [31:0]                f1_load_x_r, f1_load_y_r;
  logic [eot_pkg::STEP_BITS-1:0]     f1_step_r;
  eot_pkg::eot_trig_t                f1_tcos_r, f1_tsin_r, f1_ocos_r, f1_osin_r;

  // Stage 2: raw products.
  logic                              f2_v_r;
  eot_pkg::eot_op_t                  f2_op_r;
  logic signed [31:0]                f2_load_x_r, f2_load_y_r;
  logic [eot_pkg::PROD_BITS-1:0]     f2_dx_r, f2_dy_r, f2_ox_r, f2_oy_r;
  logic                              f2_dx_neg_r, f2_dy_neg_r, f2_ox_neg_r, f2_oy_neg_r;

  assign accept = in_push && !in_full;
  assign in_full = (cnt_r == CW'(QUEUE_DEPTH));

  always_comb begin
    head_a  = ANGLE_BITS'(in_word.heading);
    off_a   = ANGLE_BITS'(cfg.offset_angle);
    head_ph = eot_pkg::PHASE_BITS'(head_a) << SHIFT;
    off_ph  = eot_pkg::PHASE_BITS'(off_a) << SHIFT;
    tick_ph = head_ph
            + ((in_word.mode == eot_pkg::MODE_Y_TICK) ? eot_pkg::QUARTER_PH : '0)
            + (in_word.forward ? '0 : eot_pkg::HALF_PH);
    cen_ph  = head_ph + off_ph;
    unique case (in_word.mode) inside
      eot_pkg::MODE_X_TICK, eot_pkg::MODE_Y_TICK: op = eot_pkg::OP_MOVE;
      eot_pkg::MODE_LOAD:                         op = eot_pkg::OP_LOAD;
      default:                                    op = eot_pkg::OP_HOLD;
    endcase
  end

  // Credits cover both stages and the queue behind them.
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && !mid_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (mid_pop && !accept) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      f1_v_r <= accept;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_op_r     <= op;
    f1_load_x_r <= in_word.load_x;
    f1_load_y_r <= in_word.load_y;
    f1_step_r   <= (in_word.mode == eot_pkg::MODE_Y_TICK) ? cfg.step_y : cfg.step_x;
    f1_tcos_r   <= eot_pkg::sine_q15(tick_ph + eot_pkg::QUARTER_PH);
    f1_tsin_r   <= eot_pkg::sine_q15(tick_ph);
    f1_ocos_r   <= eot_pkg::sine_q15(cen_ph + eot_pkg::QUARTER_PH);
    f1_osin_r   <= eot_pkg::sine_q15(cen_ph);
  end

  always_ff @(posedge clk) begin
    f2_op_r     <= f1_op_r;
    f2_load_x_r <= f1_load_x_r;
    f2_load_y_r <= f1_load_y_r;
    f2_dx_r     <= eot_pkg::PROD_BITS'(f1_step_r) * eot_pkg::PROD_BITS'(f1_tcos_r.mag);
    f2_dy_r     <= eot_pkg::PROD_BITS'(f1_step_r) * eot_pkg::PROD_BITS'(f1_tsin_r.mag);
    f2_ox_r     <= eot_pkg::PROD_BITS'(cfg.center_distance)
                 * eot_pkg::PROD_BITS'(f1_ocos_r.mag);
    f2_oy_r     <= eot_pkg::PROD_BITS'(cfg.center_distance)
                 * eot_pkg::PROD_BITS'(f1_osin_r.mag);
    f2_dx_neg_r <= f1_tcos_r.neg;
    f2_dy_neg_r <= f1_tsin_r.neg;
    f2_ox_neg_r <= f1_ocos_r.neg;
    f2_oy_neg_r <= f1_osin_r.neg;
  end

  always_comb begin
    mid_push        = f2_v_r;
    mid_word.op     = f2_op_r;
    mid_word.load_x = f2_load_x_r;
    mid_word.load_y = f2_load_y_r;
    mid_word.dx     = eot_pkg::scale_round(f2_dx_r, f2_dx_neg_r);
    mid_word.dy     = eot_pkg::scale_round(f2_dy_r, f2_dy_neg_r);
    mid_word.ox     = eot_pkg::scale_round(f2_ox_r, f2_ox_neg_r);
    mid_word.oy     = eot_pkg::scale_round(f2_oy_r, f2_oy_neg_r);
  end

  `EOT_ASSERT_NEVER(a_front_credit_covers_stages,
    $countones({f1_v_r, f2_v_r}) > int'(cnt_r), "front credits below words in flight")

endmodule

// File: sv/eot_back.sv
// Back end: the tracker accumulator and the centre position with saturation.
// Depends on eot_pkg and encoder_odometry_tracker_unit_defines.svh.
`include "encoder_odometry_tracker_unit_defines.svh"

module eot_back #(
  parameter int POS_BITS    = eot_pkg::POS_BITS_DEF,
  parameter int QUEUE_DEPTH = eot_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   mid_empty,
  input  eot_pkg::eot_mid_word_t mid_word,
  output logic                   mid_pop,
  input  logic                   out_taken,
  output logic                   out_push,
  output eot_pkg::eot_out_word_t out_word
);

  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = ((POS_BITS > 32) ? POS_BITS : 32) + 2;

  localparam logic signed [SUM_W-1:0] POS_HI = (SUM_W'(1) << (POS_BITS - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] POS_LO = -POS_HI - SUM_W'(1);
  // Clamping to the stored width and then to 32 bits is one clamp to the tighter range.
  localparam logic signed [SUM_W-1:0] OUT_HI =
    (POS_BITS < 32) ? POS_HI : ((SUM_W'(1) << 31) - SUM_W'(1));
  localparam logic signed [SUM_W-1:0] OUT_LO = -OUT_HI - SUM_W'(1);

  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        b1_v_r;
  logic signed [POS_BITS-1:0]  track_x_r, track_x_nxt;
  logic signed [POS_BITS-1:0]  track_y_r, track_y_nxt;
  logic signed [eot_pkg::DELTA_BITS-1:0] b1_ox_r, b1_oy_r;

  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = (v > POS_HI) ? POS_HI : ((v < POS_LO) ? POS_LO : v);
    return c[POS_BITS-1:0];
  endfunction

  function automatic logic signed [31:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = (v > OUT_HI) ? OUT_HI : ((v < OUT_LO) ? OUT_LO : v);
    return c[31:0];
  endfunction

  assign mid_pop = !mid_empty && (cnt_r != CW'(QUEUE_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (mid_pop && !out_taken) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (out_taken && !mid_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    track_x_nxt = track_x_r;
    track_y_nxt = track_y_r;
    if (mid_pop) begin
      case (mid_word.op)
        eot_pkg::OP_MOVE: begin
          track_x_nxt = sat_pos(SUM_W'(track_x_r) + SUM_W'(mid_word.dx));
          track_y_nxt = sat_pos(SUM_W'(track_y_r) + SUM_W'(mid_word.dy));
        end
        eot_pkg::OP_LOAD: begin
          track_x_nxt = sat_pos(SUM_W'(mid_word.load_x) + SUM_W'(mid_word.ox));
          track_y_nxt = sat_pos(SUM_W'(mid_word.load_y) + SUM_W'(mid_word.oy));
        end
        default: begin
          track_x_nxt = track_x_r;
          track_y_nxt = track_y_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      b1_v_r    <= 1'b0;
      track_x_r <= '0;
      track_y_r <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      b1_v_r    <= mid_pop;
      track_x_r <= track_x_nxt;
      track_y_r <= track_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b1_ox_r <= mid_word.ox;
    b1_oy_r <= mid_word.oy;
  end

  // The tracker register holds the position after the word in stage 1.
  always_comb begin
    out_push          = b1_v_r;
    out_word.center_x = sat_out(SUM_W'(track_x_r) - SUM_W'(b1_ox_r));
    out_word.center_y = sat_out(SUM_W'(track_y_r) - SUM_W'(b1_oy_r));
  end

  `EOT_ASSERT_IMPLY(a_back_credit_held, b1_v_r, cnt_r != '0,
    "back credits empty with a word in stage 1")
  `EOT_ASSERT_NEVER(a_back_pop_when_empty, mid_pop && mid_empty,
    "accumulator took a word from an empty queue")

endmodule

// File: sv/encoder_odometry_tracker_unit.sv
// Top level of the two-wheel dead-reckoning odometry tracker.
// Depends on eot_pkg, eot_fifo, eot_front and eot_back.
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+----------------------------------
//   input    | in_push, in_full, in_word      | one input word per accept
//   result   | out_pop, out_empty, out_word   | centre x and y after each word
//   config   | cfg_we, cfg_index, cfg_data    | one register write per enable
//
// One word is accepted per cycle for as long as the reader keeps up; the single tracker
// add-and-saturate loop in the back end sets that figure. An accepted word passes through the
// two front stages, the middle queue, the accumulator stage and the result queue.
// Reset is synchronous and clears the queues, credits, tracker and registers; no
// clearing pass follows it. The front stalls only on its credit count and the back
// only on room in the output queue, so a stalled reader stops the front only once
// 2*QUEUE_DEPTH words are held inside the block.

module encoder_odometry_tracker_unit #(
  parameter int ANGLE_BITS  = eot_pkg::ANGLE_BITS_DEF,
  parameter int POS_BITS    = eot_pkg::POS_BITS_DEF,
  parameter int QUEUE_DEPTH = eot_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  eot_pkg::eot_in_word_t   in_word,
  input  logic                    out_pop,
  output logic                    out_empty,
  output eot_pkg::eot_out_word_t  out_word,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [eot_pkg::STEP_BITS-1:0] cfg_data
);

  eot_pkg::eot_cfg_t      cfg_r, cfg_nxt;
  logic                   mid_push, mid_pop, mid_empty;
  eot_pkg::eot_mid_word_t mid_in_word, mid_out_word;
  logic                   res_push;
  eot_pkg::eot_out_word_t res_word;
  logic                   out_taken;

  // The user must let register writes land only while the block is idle; the block does
  // not enforce it. The pipeline reads the registers directly without copies of its own.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        eot_pkg::REG_STEP_X:      cfg_nxt.step_x          = cfg_data;
        eot_pkg::REG_STEP_Y:      cfg_nxt.step_y          = cfg_data;
        eot_pkg::REG_CENTER_DIST: cfg_nxt.center_distance = cfg_data;
        eot_pkg::REG_OFFSET_ANG:  cfg_nxt.offset_angle    = cfg_data[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: classification, trig lookup and scaling of both vectors.
  eot_front #(
    .ANGLE_BITS  (ANGLE_BITS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_word  (in_word),
    .in_full  (in_full),
    .cfg      (cfg_r),
    .mid_pop  (mid_pop),
    .mid_push (mid_push),
    .mid_word (mid_in_word)
  );

  // Middle queue; the front's credit count keeps it from overflowing.
  eot_fifo #(
    .WIDTH ($bits(eot_pkg::eot_mid_word_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_data (mid_in_word),
    .pop       (mid_pop),
    .pop_data  (mid_out_word),
    .empty     (mid_empty)
  );

  // Back end: tracker accumulator and centre position.
  eot_back #(
    .POS_BITS    (POS_BITS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_word  (mid_out_word),
    .mid_pop   (mid_pop),
    .out_taken (out_taken),
    .out_push  (res_push),
    .out_word  (res_word)
  );

  assign out_taken = out_pop && !out_empty;

  // Result queue; the oldest word sits on out_word while out_empty is low.
  eot_fifo #(
    .WIDTH ($bits(eot_pkg::eot_out_word_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_word),
    .pop       (out_taken),
    .pop_data  (out_word),
    .empty     (out_empty)
  );

endmodule

// File: sim/tb.sv
// Self-checking testbench for the encoder odometry tracker top level.
// Depends on eot_pkg and encoder_odometry_tracker_unit; it predicts every result word
// with its own fixed-point model of the tracker and compares each word as it is popped.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The input mode that has no meaning: the tracker holds still but still reports.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Cycles with no word moving on either side before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_push = 1'b0;
  logic                   in_full;
  eot_pkg::eot_in_word_t  in_word = '0;
  logic                   out_pop = 1'b0;
  logic                   out_empty;
  eot_pkg::eot_out_word_t out_word;
  logic                   cfg_we = 1'b0;
  logic [1:0]             cfg_index = 2'd0;
  logic [23:0]            cfg_data = 24'd0;

  encoder_odometry_tracker_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_word  (in_word),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Centre positions predicted for accepted words, oldest first.
  eot_pkg::eot_out_word_t centers_due[$];
  int mismatches = 0;
  int feed_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  // Our own copy of the tracker state and of the four registers.
  longint      track_x = 0;
  longint      track_y = 0;
  logic [23:0] mirror_step_x = '0;
  logic [23:0] mirror_step_y = '0;
  logic [23:0] mirror_center_dist = '0;
  logic [15:0] mirror_offset = '0;

  // Quarter-wave sine samples at 1/128 turn spacing, full scale 32767.
  int sine_tbl [33] = '{
    0, 1608, 3212, 4808, 6393, 7962, 9512, 11039,
    12539, 14010, 15446, 16846, 18204, 19519, 20787, 22005,
    23170, 24279, 25329, 26319, 27245, 28105, 28898, 29621,
    30273, 30852, 31356, 31785, 32137, 32412, 32609, 32728,
    32767
  };

  // Sine of a 16-bit binary angle in Q1.15. The angle is widened to a 20-bit phase,
  // folded into the first quarter and interpolated between samples over 13 bits.
  function automatic int angle_sine(input logic [15:0] ang);
    logic [19:0] ph;
    logic [18:0] rem;
    int          seg;
    int          fr;
    int          mag;
    ph  = {ang, 4'b0000};
    rem = {1'b0, ph[17:0]};
    if (ph[18]) begin
      rem = 19'h40000 - rem;
    end
    seg = int'(rem[18:13]);
    fr  = int'(rem[12:0]);
    if (seg >= 32) begin
      mag = 32767;
    end else begin
      mag = sine_tbl[seg] + (((sine_tbl[seg+1] - sine_tbl[seg]) * fr + 4096) >> 13);
    end
    return ph[19] ? -mag : mag;
  endfunction

  // Distance times a Q1.15 trig value, rounded to nearest with halves away from zero.
  function automatic longint scaled(input logic [23:0] len, input int trig);
    longint t;
    longint m;
    t = (trig < 0) ? -longint'(trig) : longint'(trig);
    m = (longint'(len) * t + 16384) >>> 15;
    return (trig < 0) ? -m : m;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Applies one word to the tracker copy and returns the centre position it reports.
  function automatic eot_pkg::eot_out_word_t advance_tracker(input eot_pkg::eot_in_word_t w);
    eot_pkg::eot_out_word_t res;
    logic [23:0]            step_len;
    logic [15:0]            dir;
    logic [15:0]            ca;
    if (w.mode == eot_pkg::MODE_X_TICK || w.mode == eot_pkg::MODE_Y_TICK) begin
      step_len = (w.mode == eot_pkg::MODE_X_TICK) ? mirror_step_x : mirror_step_y;
      dir  = w.heading + ((w.mode == eot_pkg::MODE_Y_TICK) ? 16'h4000 : 16'h0000)
           + (w.forward ? 16'h0000 : 16'h8000);
      track_x = clamp32(track_x + scaled(step_len, angle_sine(dir + 16'h4000)));
      track_y = clamp32(track_y + scaled(step_len, angle_sine(dir)));
    end else if (w.mode == eot_pkg::MODE_LOAD) begin
      ca = mirror_offset + w.heading;
      track_x = clamp32(longint'(w.load_x)
                        + scaled(mirror_center_dist, angle_sine(ca + 16'h4000)));
      track_y = clamp32(longint'(w.load_y) + scaled(mirror_center_dist, angle_sine(ca)));
    end
    // The centre sits opposite the offset vector from the tracking point.
    ca = mirror_offset + w.heading;
    res.center_x = 32'(clamp32(track_x - scaled(mirror_center_dist, angle_sine(ca + 16'h4000))));
    res.center_y = 32'(clamp32(track_y - scaled(mirror_center_dist, angle_sine(ca))));
    return res;
  endfunction

  function automatic eot_pkg::eot_in_word_t make_word(input logic [1:0] mode,
                                                      input logic fwd,
                                                      input logic [15:0] hd,
                                                      input logic [31:0] lx,
                                                      input logic [31:0] ly);
    eot_pkg::eot_in_word_t w;
    w.mode    = mode;
    w.forward = fwd;
    w.heading = hd;
    w.load_x  = lx;
    w.load_y  = ly;
    return w;
  endfunction

  // Load coordinates lean toward the ends of the range so that saturation is hit often.
  function automatic logic [31:0] pick_position();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h7FFFFFFF - 32'($urandom_range(0, 24'hFFFFFF));
      3: return 32'h80000000 + 32'($urandom_range(0, 24'hFFFFFF));
      default: return $urandom;
    endcase
  endfunction

  // Offers one word, with a random idle gap first, and holds it until it is taken.
  // The push stays high on return so that back-to-back words need no extra edge.
  task automatic send_word(input eot_pkg::eot_in_word_t w);
    if ($urandom_range(99) < feed_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < feed_idle_pct);
    end
    in_push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_full);
    centers_due.push_back(advance_tracker(w));
  endtask

  // Stops offering words and waits until every predicted word has been popped,
  // then lets the pipeline run on so that the block is truly idle.
  task automatic settle_block();
    in_push <= 1'b0;
    @(posedge clk);
    while (centers_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      eot_pkg::REG_STEP_X:      mirror_step_x = data;
      eot_pkg::REG_STEP_Y:      mirror_step_y = data;
      eot_pkg::REG_CENTER_DIST: mirror_center_dist = data;
      eot_pkg::REG_OFFSET_ANG:  mirror_offset = data[15:0];
      default: ;
    endcase
  endtask

  // Writes all four registers; only called while nothing is in flight.
  task automatic configure(input logic [23:0] sx, input logic [23:0] sy,
                           input logic [23:0] cd, input logic [23:0] oa);
    write_reg(eot_pkg::REG_STEP_X, sx);
    write_reg(eot_pkg::REG_STEP_Y, sy);
    write_reg(eot_pkg::REG_CENTER_DIST, cd);
    write_reg(eot_pkg::REG_OFFSET_ANG, oa);
    cfg_we <= 1'b0;
  endtask

  // With every register still at its reset value of zero, ticks move nothing and the
  // centre is exactly the tracker; a load places it directly.
  task automatic test_reset_values();
    send_word(make_word(eot_pkg::MODE_X_TICK, 1'b1, 16'h1234, 32'h0, 32'h0));
    send_word(make_word(eot_pkg::MODE_LOAD, 1'b0, 16'hFFFF, 32'd5, -32'sd7));
    send_word(make_word(MODE_UNUSED, 1'b1, 16'h0000, 32'hFFFFFFFF, 32'hFFFFFFFF));
    settle_block();
  endtask

  // Both wheels forward and backward at the cardinal angles and a few angles that
  // land between table samples, with no centre offset.
  task automatic test_tick_directions();
    configure(24'hFFFFFF, 24'h00ABCD, 24'h000000, 24'h000000);
    send_word(make_word(eot_pkg::MODE_X_TICK, 1'b1, 16'h0000, 32'h0, 32'h0));
    send_word(make_word(eot_pkg::MODE_X_TICK, 1'b0, 16'h0000, 32'h0, 32'h0));
    send_word(make_word(eot_pkg::MODE_X_TICK, 1'b1, 16'h4000, 32'h0, 32'h0));
    send_word(make_word(eot_pkg::MODE_Y_TICK, 1'b1, 16'h0000, 32'h0, 32'h0));
    send_word(make_word(eot_pkg::MODE_Y_TICK, 1'b0, 16'h8000, 32'h0, 32'h0));
    send_word(make_word(eot_pkg::MODE_X_TICK, 1'b1, 16'hFFFF, 32'h0, 32'h0));
    send_word(make_word(eot_pkg::MODE_Y_TICK, 1'b1, 16'h1FFF, 32'h0, 32'h0));
    send_word(make_word(eot_pkg::MODE_X_TICK, 1'b0, 16'hC001, 32'h0, 32'h0));
    settle_block();
  endtask

  // Loads at the ends of the position range with the largest offset vector, so that
  // both the stored tracker and the reported centre clamp.
  task automatic test_loads_and_saturation();
    configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_word(make_word(eot_pkg::MODE_LOAD, 1'b1, 16'h0000, 32'h7FFFFFFF, 32'h7FFFFFFF));
    send_word(make_word(eot_pkg::MODE_X_TICK, 1'b1, 16'h0000, 32'h0, 32'h0));
    send_word(make_word(eot_pkg::MODE_LOAD, 1'b0, 16'h8000, 32'h80000000, 32'h80000000));
    send_word(make_word(eot_pkg::MODE_Y_TICK, 1'b0, 16'h0000, 32'h0, 32'h0));
    send_word(make_word(eot_pkg::MODE_LOAD, 1'b1, 16'h0001, 32'h0, 32'h0));
    send_word(make_word(eot_pkg::MODE_LOAD, 1'b1, 16'h4000, 32'h7FFFFFFF, 32'h80000000));
    settle_block();
  endtask

  // Fields that a mode does not use must not matter: the unused mode holds the tracker,
  // ticks ignore the load coordinates and loads ignore the direction level.
  task automatic test_ignored_fields();
    send_word(make_word(MODE_UNUSED, 1'b0, 16'hABCD, 32'h7FFFFFFF, 32'h80000000));
    send_word(make_word(MODE_UNUSED, 1'b1, 16'h5555, 32'h80000000, 32'h7FFFFFFF));
    send_word(make_word(eot_pkg::MODE_X_TICK, 1'b1, 16'h2000, 32'hDEADBEEF, 32'h12345678));
    send_word(make_word(eot_pkg::MODE_LOAD, 1'b0, 16'h2000, 32'h00010000, 32'hFFFF0000));
    settle_block();
  endtask

  // One random phase: write the registers, then mostly bursts of ticks from one wheel
  // (long enough to drive the tracker into saturation), with loads and unused-mode words.
  task automatic run_traffic(input int n, input int sidle, input int rstall,
                             input logic [23:0] sx, input logic [23:0] sy,
                             input logic [23:0] cd, input logic [23:0] oa);
    int          left;
    int          burst;
    int          kind;
    logic [1:0]  mode;
    logic        fwd;
    logic [15:0] hd;
    logic        sweep;
    configure(sx, sy, cd, oa);
    feed_idle_pct = sidle;
    stall_pct     = rstall;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(99);
      if (kind < 8) begin
        send_word(make_word(eot_pkg::MODE_LOAD, 1'($urandom_range(1)), 16'($urandom),
                            pick_position(), pick_position()));
        left--;
      end else if (kind < 11) begin
        send_word(make_word(MODE_UNUSED, 1'($urandom_range(1)), 16'($urandom),
                            $urandom, $urandom));
        left--;
      end else begin
        burst = $urandom_range(1, 40);
        if (burst > left) burst = left;
        mode  = $urandom_range(1) ? eot_pkg::MODE_Y_TICK : eot_pkg::MODE_X_TICK;
        fwd   = 1'($urandom_range(1));
        hd    = 16'($urandom);
        sweep = 1'($urandom_range(1));
        repeat (burst) begin
          if (sweep) hd = 16'($urandom);
          if ($urandom_range(9) == 0) fwd = ~fwd;
          send_word(make_word(mode, fwd, hd, $urandom, $urandom));
          left--;
        end
      end
    end
    settle_block();
  endtask

  task automatic test_random_traffic();
    run_traffic(200, 0, 0, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    run_traffic(150, 84, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    run_traffic(150, 0, 84, 24'($urandom_range(0, 65535)), 24'($urandom_range(0, 65535)),
                24'($urandom), 24'($urandom));
    run_traffic(100, 9, 9, 24'h000000, 24'h000000, 24'hFFFFFF, 24'($urandom));
    run_traffic(200, 0, 0, 24'($urandom), 24'($urandom), 24'($urandom), 24'h000000);
    run_traffic(150, 9, 9, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
  endtask

  // Result side: compare the popped word against the oldest prediction, then decide
  // whether to pop on the next edge.
  always @(posedge clk) begin : check_results
    eot_pkg::eot_out_word_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (centers_due.size() == 0) begin
        mismatches++;
        $display("%0t ns: word popped with nothing expected, got x=%0d y=%0d",
                 $time, out_word.center_x, out_word.center_y);
      end else begin
        want = centers_due.pop_front();
        if (out_word.center_x !== want.center_x) begin
          mismatches++;
          $display("%0t ns: center_x expected %0d, got %0d",
                   $time, want.center_x, out_word.center_x);
        end
        if (out_word.center_y !== want.center_y) begin
          mismatches++;
          $display("%0t ns: center_y expected %0d, got %0d",
                   $time, want.center_y, out_word.center_y);
        end
      end
    end
    out_pop <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: a long run of edges at which no word moves on either side means a hang.
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL encoder_odometry_tracker_unit");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_tick_directions();
    test_loads_and_saturation();
    test_ignored_fields();
    test_random_traffic();
    if (centers_due.size() != 0) begin
      mismatches++;
      $display("%0t ns: %0d predicted words never arrived", $time, centers_due.size());
    end
    if (mismatches == 0) begin
      $display("PASS encoder_odometry_tracker_unit");
    end else begin
      $display("FAIL encoder_odometry_tracker_unit");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/eot_pkg.sv
sv/eot_fifo.sv
sv/eot_front.sv
sv/eot_back.sv
sv/encoder_odometry_tracker_unit.sv
sim/tb.sv
